// ===== src/spt_pkg.sv =====
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants for the sorted prefix table: entry layout,
// table sizing, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package spt_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W      = 32;
	localparam int PLEN_W      = 6;
	localparam int RANK_W      = 8;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [ADDR_W-1:0] net;
		logic [PLEN_W-1:0] plen;
		logic [RANK_W-1:0] rank;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} mem_wr_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_CMP,
		S_DUPCHK,
		S_SH_RD,
		S_SH_WR,
		S_MATCH
	} state_t;

	// network mask with plen leading ones, plen already saturated
	function automatic logic [ADDR_W-1:0] mask_of(input logic [PLEN_W-1:0] plen);
		logic [ADDR_W-1:0] m;
		if (plen == '0)
			m = '0;
		else
			m = {ADDR_W{1'b1}} << (PLEN_W'(ADDR_W) - plen);
		return m;
	endfunction

endpackage

// ===== src/sorted_ip_prefix_table.sv =====
// ----------------------------------------------------------------------------
// sorted_ip_prefix_table
// Ascending table of IPv4 network entries with clear, sorted insert and
// binary-search lookup, all driven by one compare unit under a sequencer.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------
//  command   start & !busy        operation, address, entry_rank,
//                                 prefix_length
//  result    done (one cycle)     hit, found_rank, status
//
//  clear and unused opcode: result in the cycle after acceptance.
//  lookup: s search steps, s <= ceil(log2(count+1)), each a memory read
//  plus a compare on the single read port, then a prefix match on one read
//  entry, none on an empty table. insert: the search, a duplicate check if
//  the entry lands below count, a read and a write per entry shifted up.
//  arst_n empties the table (count to zero); entry storage is not cleared.
//  busy is high after an insert or lookup is accepted until the cycle the result appears;
//  the receiver cannot stall, so each result is shown exactly once.
// ----------------------------------------------------------------------------
module sorted_ip_prefix_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  operation,
	input  logic [spt_pkg::ADDR_W-1:0]  address,
	input  logic [spt_pkg::RANK_W-1:0]  entry_rank,
	input  logic [spt_pkg::PLEN_W-1:0]  prefix_length,
	output logic                        done,
	output logic                        hit,
	output logic [spt_pkg::RANK_W-1:0]  found_rank,
	output logic [1:0]                  status
);
	import spt_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [CNT_W-1:0]  lo_q, lo_d;
	logic [CNT_W-1:0]  hi_q, hi_d;
	logic [CNT_W-1:0]  sh_q, sh_d;
	logic [CNT_W-1:0]  mid;
	logic [1:0]        op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [RANK_W-1:0] rank_q;
	logic [PLEN_W-1:0] plen_q;
	logic              accept;

	logic              fin;
	logic              fin_hit;
	logic [RANK_W-1:0] fin_rank;
	status_t           fin_status;
	logic              done_q, hit_q;
	logic [RANK_W-1:0] rank_out_q;
	status_t           status_q;

	mem_wr_t           wr;
	logic [CNT_W-1:0]  rd_idx;
	entry_t            rdata;

	spt_table u_table (
		.clk   (clk),
		.wr    (wr),
		.raddr (rd_idx[IDX_W-1:0]),
		.rdata (rdata)
	);

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign mid    = lo_q + ((hi_q - lo_q) >> 1);

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		lo_d       = lo_q;
		hi_d       = hi_q;
		sh_d       = sh_q;
		rd_idx     = mid;
		wr.en      = 1'b0;
		wr.addr    = sh_q[IDX_W-1:0];
		wr.data    = rdata;
		fin        = 1'b0;
		fin_hit    = 1'b0;
		fin_rank   = '0;
		fin_status = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					lo_d = '0;
					hi_d = cnt_q;
					unique case (operation)
						OP_CLEAR: begin
							cnt_d = '0;
							fin   = 1'b1;
						end
						OP_INSERT, OP_LOOKUP: state_d = S_SEARCH;
						default: fin = 1'b1;
					endcase
				end
			end
			S_SEARCH: begin
				if (lo_q < hi_q) begin
					rd_idx  = mid;
					state_d = S_CMP;
				end else if (op_q == OP_INSERT) begin
					rd_idx = lo_q;
					if (lo_q < cnt_q) begin
						state_d = S_DUPCHK;
					end else if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
						fin        = 1'b1;
						fin_status = ST_FULL;
						state_d    = S_IDLE;
					end else begin
						sh_d    = cnt_q;
						state_d = S_SH_RD;
					end
				end else begin
					rd_idx = (lo_q == '0) ? '0 : lo_q - 1'b1;
					if (cnt_q == '0) begin
						fin     = 1'b1;
						state_d = S_IDLE;
					end else begin
						state_d = S_MATCH;
					end
				end
			end
			S_CMP: begin
				// insert seeks first net >= key, lookup first net > key
				if ((rdata.net < addr_q) || ((op_q == OP_LOOKUP) && (rdata.net == addr_q)))
					lo_d = mid + 1'b1;
				else
					hi_d = mid;
				state_d = S_SEARCH;
			end
			S_DUPCHK: begin
				if (rdata.net == addr_q) begin
					fin        = 1'b1;
					fin_status = ST_DUP;
					state_d    = S_IDLE;
				end else if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
					fin        = 1'b1;
					fin_status = ST_FULL;
					state_d    = S_IDLE;
				end else begin
					sh_d    = cnt_q;
					state_d = S_SH_RD;
				end
			end
			S_SH_RD: begin
				if (sh_q == lo_q) begin
					wr.en        = 1'b1;
					wr.addr      = lo_q[IDX_W-1:0];
					wr.data.net  = addr_q;
					wr.data.plen = plen_q;
					wr.data.rank = rank_q;
					cnt_d        = cnt_q + 1'b1;
					fin          = 1'b1;
					state_d      = S_IDLE;
				end else begin
					rd_idx  = sh_q - 1'b1;
					state_d = S_SH_WR;
				end
			end
			S_SH_WR: begin
				// move one entry up by one slot
				wr.en   = 1'b1;
				wr.addr = sh_q[IDX_W-1:0];
				sh_d    = sh_q - 1'b1;
				state_d = S_SH_RD;
			end
			S_MATCH: begin
				fin = 1'b1;
				if ((addr_q & mask_of(rdata.plen)) == rdata.net) begin
					fin_hit  = 1'b1;
					fin_rank = rdata.rank;
				end
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			lo_q    <= '0;
			hi_q    <= '0;
			sh_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			lo_q    <= lo_d;
			hi_q    <= hi_d;
			sh_q    <= sh_d;
			done_q  <= fin;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= operation;
			addr_q <= address;
			rank_q <= entry_rank;
			plen_q <= (prefix_length > PLEN_W'(ADDR_W)) ? PLEN_W'(ADDR_W) : prefix_length;
		end
		if (fin) begin
			hit_q      <= fin_hit;
			rank_out_q <= fin_rank;
			status_q   <= fin_status;
		end
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign found_rank = rank_out_q;
	assign status     = status_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count above table depth");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while a transaction is still running");

	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit) |-> (status == ST_OK))
		else $error("hit reported with a non-zero status");

	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> ((lo_q <= hi_q) && (hi_q <= cnt_q)))
		else $error("search window out of range");

endmodule

// ===== src/spt_table.sv =====
// ----------------------------------------------------------------------------
// spt_table
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spt_table (
	input  logic                  clk,
	input  spt_pkg::mem_wr_t      wr,
	input  logic [spt_pkg::IDX_W-1:0] raddr,
	output spt_pkg::entry_t       rdata
);
	import spt_pkg::*;

	entry_t mem_q [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en)
			mem_q[wr.addr] <= wr.data;
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== tb/sv/sorted_ip_prefix_table_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_ip_prefix_table_tb
// Self-checking bench for the sorted prefix table. A shadow copy of the
// table predicts each result that is not typed. A short directed table
// covers the edge cases. A fill to full depth checks the full and duplicate
// drops. The random part mixes clears, unused opcodes, inserts and lookups
// with random sender gaps; lookups mostly land inside stored networks. Each
// result is compared field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module sorted_ip_prefix_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spt_pkg::*;

	localparam logic [1:0] OP_NOP = 2'd3;

	typedef struct packed {
		logic       hit;
		logic [7:0] frank;
		status_t    st;
	} outcome_t;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] addr;
		logic [7:0]  rank;
		logic [5:0]  plen;
		bit          typed;
		logic        hit;
		logic [7:0]  frank;
		status_t     st;
	} stim_row_t;

	localparam int N_ROWS = 23;

	// typed rows carry a result that is obvious; the rest use the shadow's result
	stim_row_t directed_rows [N_ROWS] = '{
		'{OP_LOOKUP, 32'h0000_0000, 8'h00, 6'd0,  1'b1, 1'b0, 8'h00, ST_OK},
		'{OP_INSERT, 32'h0000_0000, 8'h11, 6'd0,  1'b1, 1'b0, 8'h00, ST_OK},
		'{OP_LOOKUP, 32'hFFFF_FFFF, 8'h00, 6'd0,  1'b1, 1'b1, 8'h11, ST_OK},
		'{OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 6'd32, 1'b1, 1'b0, 8'h00, ST_OK},
		'{OP_INSERT, 32'hFFFF_FFFF, 8'h00, 6'd63, 1'b1, 1'b0, 8'h00, ST_DUP},
		'{OP_LOOKUP, 32'hFFFF_FFFF, 8'hFF, 6'd63, 1'b1, 1'b1, 8'hFF, ST_OK},
		'{OP_INSERT, 32'h0A00_0000, 8'h05, 6'd8,  1'b0, 1'b0, 8'h00, ST_OK},
		'{OP_LOOKUP, 32'h0AFF_FFFF, 8'h00, 6'd0,  1'b0, 1'b0, 8'h00, ST_OK},
		'{OP_LOOKUP, 32'h0B00_0000, 8'h00, 6'd0,  1'b0, 1'b0, 8'h00, ST_OK},
		'{OP_INSERT, 32'hC0A8_0100, 8'h07, 6'd63, 1'b0, 1'b0, 8'h00, ST_OK},
		'{OP_LOOKUP, 32'hC0A8_0100, 8'h00, 6'd0,  1'b0, 1'b0, 8'h00, ST_OK},
		'{OP_LOOKUP, 32'hC0A8_0101, 8'h00, 6'd0,  1'b0, 1'b0, 8'h00, ST_OK},
		'{OP_INSERT, 32'h0B00_0001, 8'h09, 6'd8,  1'b0, 1'b0, 8'h00, ST_OK},
		'{OP_LOOKUP, 32'h0B00_0001, 8'h00, 6'd0,  1'b0, 1'b0, 8'h00, ST_OK},
		'{OP_NOP,    32'hFFFF_FFFF, 8'hFF, 6'd63, 1'b1, 1'b0, 8'h00, ST_OK},
		'{OP_CLEAR,  32'hFFFF_FFFF, 8'hFF, 6'd63, 1'b1, 1'b0, 8'h00, ST_OK},
		'{OP_LOOKUP, 32'h0000_0000, 8'h00, 6'd0,  1'b1, 1'b0, 8'h00, ST_OK},
		'{OP_INSERT, 32'h8000_0000, 8'h80, 6'd1,  1'b1, 1'b0, 8'h00, ST_OK},
		'{OP_LOOKUP, 32'h7FFF_FFFF, 8'h00, 6'd0,  1'b0, 1'b0, 8'h00, ST_OK},
		'{OP_LOOKUP, 32'hFFFF_FFFF, 8'h00, 6'd0,  1'b0, 1'b0, 8'h00, ST_OK},
		'{OP_INSERT, 32'h0000_0000, 8'h3C, 6'd0,  1'b0, 1'b0, 8'h00, ST_OK},
		'{OP_LOOKUP, 32'h1234_5678, 8'h00, 6'd0,  1'b0, 1'b0, 8'h00, ST_OK},
		'{OP_CLEAR,  32'h0000_0000, 8'h00, 6'd0,  1'b1, 1'b0, 8'h00, ST_OK}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  operation = OP_CLEAR;
	logic [31:0] address = '0;
	logic [7:0]  entry_rank = '0;
	logic [5:0]  prefix_length = '0;
	logic        done;
	logic        hit;
	logic [7:0]  found_rank;
	logic [1:0]  status;

	entry_t   shadow_entries [TABLE_DEPTH];
	int       shadow_count = 0;
	outcome_t pending_outcomes [$];
	int       fail_count = 0;

	sorted_ip_prefix_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.address       (address),
		.entry_rank    (entry_rank),
		.prefix_length (prefix_length),
		.done          (done),
		.hit           (hit),
		.found_rank    (found_rank),
		.status        (status)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// leading ones from the top of a 64-bit window, plen already saturated
	function automatic logic [31:0] net_mask(input logic [5:0] plen);
		logic [63:0] w;
		w = 64'hFFFF_FFFF_0000_0000 >> plen;
		return w[31:0];
	endfunction

	// applies one transaction to the shadow table and returns its result
	function automatic outcome_t apply_to_shadow_table(input logic [1:0] op,
			input logic [31:0] addr, input logic [7:0] rank, input logic [5:0] plen);
		outcome_t   res;
		int         pos;
		int         sel;
		logic [5:0] eff;
		res = '{1'b0, 8'h00, ST_OK};
		eff = (plen > 6'd32) ? 6'd32 : plen;
		case (op)
			OP_CLEAR: begin
				shadow_count = 0;
			end
			OP_INSERT: begin
				pos = 0;
				while (pos < shadow_count && shadow_entries[pos].net < addr)
					pos++;
				if (pos < shadow_count && shadow_entries[pos].net == addr) begin
					res.st = ST_DUP;
				end else if (shadow_count >= TABLE_DEPTH) begin
					res.st = ST_FULL;
				end else begin
					for (int j = shadow_count; j > pos; j--)
						shadow_entries[j] = shadow_entries[j-1];
					shadow_entries[pos] = '{net: addr, plen: eff, rank: rank};
					shadow_count++;
				end
			end
			OP_LOOKUP: begin
				if (shadow_count > 0) begin
					// greatest entry not above the query, else entry 0
					sel = 0;
					while (sel + 1 < shadow_count && shadow_entries[sel+1].net <= addr)
						sel++;
					if ((addr & net_mask(shadow_entries[sel].plen)) == shadow_entries[sel].net) begin
						res.hit   = 1'b1;
						res.frank = shadow_entries[sel].rank;
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// drives one command, waits for the transaction, queues its result
	task automatic issue_cmd(input logic [1:0] op, input logic [31:0] addr,
			input logic [7:0] rank, input logic [5:0] plen,
			input bit typed, input outcome_t fixed);
		outcome_t predicted;
		operation     <= op;
		address       <= addr;
		entry_rank    <= rank;
		prefix_length <= plen;
		start         <= 1'b1;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		predicted = apply_to_shadow_table(op, addr, rank, plen);
		pending_outcomes.push_back(typed ? fixed : predicted);
	endtask

	task automatic sender_gap(input int pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin : result_check
		outcome_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_outcomes.size() == 0) begin
				$error("result with no transaction pending");
				fail_count++;
			end else begin
				want = pending_outcomes.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, hit);
					fail_count++;
				end
				if (found_rank !== want.frank) begin
					$error("found_rank: expected %0d, got %0d", want.frank, found_rank);
					fail_count++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		int          idx;
		int          pick;
		int          pct;
		int          idle_pct [4];
		logic [1:0]  op;
		logic [31:0] a;
		logic [7:0]  rk;
		logic [5:0]  pl;
		logic [5:0]  eff;
		entry_t      e;
		outcome_t    blank;
		outcome_t    fixed;

		blank = '{1'b0, 8'h00, ST_OK};
		idle_pct = '{0, 62, 0, 37};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			fixed = '{directed_rows[i].hit, directed_rows[i].frank, directed_rows[i].st};
			issue_cmd(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].rank,
				directed_rows[i].plen, directed_rows[i].typed, fixed);
		end

		// fill to full depth in ascending order so no entry is shifted
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			sender_gap(5);
			issue_cmd(OP_INSERT, 32'(i) << 22, 8'(i), 6'd10, 1'b0, blank);
		end
		issue_cmd(OP_INSERT, 32'h0000_0001, 8'h55, 6'd32, 1'b1, '{1'b0, 8'h00, ST_FULL});
		// duplicate is reported ahead of full
		issue_cmd(OP_INSERT, 32'h0040_0000, 8'h55, 6'd10, 1'b1, '{1'b0, 8'h00, ST_DUP});
		for (int i = 0; i < 40; i++) begin
			a = (i % 2 == 0) ? $urandom : (32'($urandom_range(TABLE_DEPTH - 1)) << 22);
			issue_cmd(OP_LOOKUP, a, 8'($urandom), 6'($urandom), 1'b0, blank);
		end
		issue_cmd(OP_CLEAR, 32'h0, 8'h0, 6'd0, 1'b1, blank);

		for (int n = 0; n < 520; n++) begin
			pct = idle_pct[(n / 130) % 4];
			sender_gap(pct);
			pick = $urandom_range(99);
			rk = 8'($urandom);
			pl = 6'($urandom);
			a = $urandom;
			if (pick < 2 || shadow_count >= 40 + $urandom_range(20)) begin
				op = OP_CLEAR;
			end else if (pick < 5) begin
				op = OP_NOP;
			end else if (pick < 45) begin
				op = OP_INSERT;
				if ($urandom_range(9) != 0)
					pl = 6'($urandom_range(8, 32));
				eff = (pl > 6'd32) ? 6'd32 : pl;
				pick = $urandom_range(99);
				if (shadow_count > 0 && pick < 50) begin
					idx = $urandom_range(shadow_count - 1);
					e = shadow_entries[idx];
					// exact duplicate, or a sibling/nested network of a stored entry
					if (pick < 20)
						a = e.net;
					else
						a = e.net | ($urandom & ~net_mask(e.plen));
				end
				if (pick >= 20 && $urandom_range(9) != 0)
					a = a & net_mask(eff);
			end else begin
				op = OP_LOOKUP;
				pick = $urandom_range(99);
				if (shadow_count > 0 && pick < 70) begin
					idx = $urandom_range(shadow_count - 1);
					e = shadow_entries[idx];
					if (pick < 10)
						a = e.net - 32'd1;
					else
						a = e.net | ($urandom & ~net_mask(e.plen));
				end
			end
			issue_cmd(op, a, rk, pl, 1'b0, blank);
		end
		start <= 1'b0;

		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("** sorted_ip_prefix_table: PASSED **");
		end else begin
			$display("** sorted_ip_prefix_table: FAILED **");
		end
		$finish;
	end

	initial begin : watchdog
		#40_000_000;
		$display("** sorted_ip_prefix_table: FAILED **");
		$finish;
	end

endmodule

// ===== sim.f =====
src/spt_pkg.sv
src/spt_table.sv
src/sorted_ip_prefix_table.sv
tb/sv/sorted_ip_prefix_table_tb.sv
